[hdl/periodic_waveform_generator_top_macros.svh]
`ifndef PERIODIC_WAVEFORM_GENERATOR_TOP_MACROS_SVH
`define PERIODIC_WAVEFORM_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, checked on clk with reset masked.
`define PWG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PWG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/pwg_pkg.sv]
package pwg_pkg;

  localparam int MAX_SAMPLES   = 4096;
  localparam int DAC_BITS      = 12;
  localparam int CORDIC_STEPS  = 16;
  localparam int CORDIC_GAIN   = 39797;
  localparam int TWO_PI_Q16    = 411775;
  localparam int DAC_FULL      = (1 << DAC_BITS) - 1;
  localparam int CW            = 20;   // cordic datapath width
  localparam int DIVIDEND_W    = 28;
  localparam int DIVISOR_W     = 14;
  localparam int QUOT_W        = 16;

  localparam logic [1:0] CFG_SHAPE   = 2'd0;
  localparam logic [1:0] CFG_NSAMP   = 2'd1;
  localparam logic [1:0] CFG_RELOAD  = 2'd2;
  localparam logic [1:0] CFG_RUNNING = 2'd3;

  localparam logic [1:0] SHAPE_SINE = 2'd0;
  localparam logic [1:0] SHAPE_TRI  = 2'd1;
  localparam logic [1:0] SHAPE_SAW  = 2'd2;
  localparam logic [1:0] SHAPE_OFF  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_ZMUL, ST_CORD, ST_SCALE, ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_vec_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic signed [CW-1:0] atan_q16(input int k);
    logic signed [CW-1:0] v;
    case (k)
      0: v = 20'sd51472;
      1: v = 20'sd30385;
      2: v = 20'sd16055;
      3: v = 20'sd8150;
      4: v = 20'sd4091;
      5: v = 20'sd2047;
      6: v = 20'sd1024;
      7: v = 20'sd512;
      8: v = 20'sd256;
      9: v = 20'sd128;
      10: v = 20'sd64;
      11: v = 20'sd32;
      12: v = 20'sd16;
      13: v = 20'sd8;
      14: v = 20'sd4;
      15: v = 20'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hdl/pwg_div.sv]
module pwg_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pwg_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [pwg_pkg::DIVISOR_W-1:0]  divisor,
  output pwg_pkg::div_status_t           status,
  output logic [pwg_pkg::QUOT_W-1:0]     quotient
);
  import pwg_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [4:0]            cnt_r, cnt_nxt;
  logic [DIVISOR_W:0]    rem_r, rem_nxt;
  logic [QUOT_W-1:0]     lo_r, lo_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [DIVISOR_W+1:0]  trial;

  // Restoring division: one quotient bit per cycle, MSB first.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, lo_r[QUOT_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = (DIVISOR_W+1)'(dividend[DIVIDEND_W-1:QUOT_W]);
      lo_nxt   = dividend[QUOT_W-1:0];
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {2'b00, dvs_r}) begin
        rem_nxt = (DIVISOR_W+1)'(trial - {2'b00, dvs_r});
        lo_nxt  = {lo_r[QUOT_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVISOR_W:0];
        lo_nxt  = {lo_r[QUOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(QUOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = lo_r;
endmodule

[hdl/pwg_cordic_cell.sv]
module pwg_cordic_cell #(
  parameter int K = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_in,
  input  pwg_pkg::cordic_vec_t vec_in,
  output logic                 vld_out,
  output pwg_pkg::cordic_vec_t vec_out
);
  import pwg_pkg::*;

  localparam logic signed [CW-1:0] ANGLE = atan_q16(K);

  logic        vld_r;
  cordic_vec_t vec_r, vec_nxt;
  logic signed [CW-1:0] dx, dy;

  always_comb begin
    dx = vec_in.y >>> K;
    dy = vec_in.x >>> K;
    if (!vec_in.z[CW-1]) begin
      vec_nxt.x = vec_in.x - dx;
      vec_nxt.y = vec_in.y + dy;
      vec_nxt.z = vec_in.z - ANGLE;
    end else begin
      vec_nxt.x = vec_in.x + dx;
      vec_nxt.y = vec_in.y - dy;
      vec_nxt.z = vec_in.z + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    vec_r <= vec_nxt;
  end

  assign vld_out = vld_r;
  assign vec_out = vec_r;
endmodule

[hdl/pwg_cordic_chain.sv]
module pwg_cordic_chain (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_in,
  input  pwg_pkg::cordic_vec_t vec_in,
  output logic                 vld_out,
  output pwg_pkg::cordic_vec_t vec_out
);
  import pwg_pkg::*;

  logic        vld [CORDIC_STEPS+1];
  cordic_vec_t vec [CORDIC_STEPS+1];

  assign vld[0] = vld_in;
  assign vec[0] = vec_in;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    pwg_cordic_cell #(.K(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .vld_in  (vld[g]),
      .vec_in  (vec[g]),
      .vld_out (vld[g+1]),
      .vec_out (vec[g+1])
    );
  end

  assign vld_out = vld[CORDIC_STEPS];
  assign vec_out = vec[CORDIC_STEPS];
endmodule

[hdl/periodic_waveform_generator_top.sv]
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_stall    | in_tick
// out     | output    | out_valid / out_stall  | out_dac_sample, out_sample_index,
//         |           |                        | out_period_start
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A tick that emits nothing does not stall the input. A sample is loaded into the
// output register after the serial divider for triangle and sawtooth, after the
// divider, multiply step, cordic cell row and scale step for sine, and directly as
// zero for the off shape. The input stalls until the sample is loaded.
// Reset is synchronous, active low, and resets all control state.
// A stalled result sits in the output register; the next tick is still taken.
`include "periodic_waveform_generator_top_macros.svh"

module periodic_waveform_generator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_tick,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_dac_sample,
  output logic [11:0] out_sample_index,
  output logic        out_period_start,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pwg_pkg::*;

  state_t state_r, state_nxt;

  logic [1:0]  shape_r;
  logic [12:0] nsamp_r;
  logic [15:0] reload_r;
  logic        running_r;
  logic [15:0] cnt_r, cnt_nxt;
  logic [11:0] phase_r, phase_nxt;

  logic [1:0]  cur_shape_r;
  logic [11:0] cur_idx_r;
  logic [11:0] sample_r, sample_nxt;
  logic [16:0] z_r;
  logic [1:0]  quad_r;
  logic signed [17:0] c_r;
  logic        cord_start_r;

  logic        out_valid_r;
  logic [11:0] out_sample_r, out_idx_r;
  logic        out_start_r;

  logic        accept, fire, out_load;
  logic [12:0] n_eff;
  logic [11:0] i_eff;
  logic [13:0] fi, fn;
  logic [14:0] fn3;
  logic [13:0] num;
  logic [DIVIDEND_W-1:0] dividend;
  logic [DIVISOR_W-1:0]  divisor;
  div_status_t div_st;
  logic [QUOT_W-1:0] quot;
  logic [32:0] zprod;
  cordic_vec_t cord_in, cord_out;
  logic        cord_vld;
  logic signed [CW-1:0] csel;
  logic [17:0] cshift;
  logic [29:0] sprod;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign fire      = accept && in_tick && running_r && (reload_r != '0)
                     && (cnt_r >= reload_r);
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    if (nsamp_r < 13'd2) begin
      n_eff = 13'd2;
    end else if (nsamp_r > 13'(MAX_SAMPLES)) begin
      n_eff = 13'(MAX_SAMPLES);
    end else begin
      n_eff = nsamp_r;
    end
    i_eff = ({1'b0, phase_r} >= n_eff) ? 12'd0 : phase_r;
    fi  = {i_eff, 2'b00};
    fn  = {1'b0, n_eff};
    fn3 = 15'(3 * {1'b0, fn});
    if (fi < fn) begin
      num = 14'(fi + fn);
    end else if ({1'b0, fi} < fn3) begin
      num = 14'(fn3 - {1'b0, fi});
    end else begin
      num = 14'({1'b0, fi} - fn3);
    end
    case (shape_r)
      SHAPE_TRI: begin
        dividend = DIVIDEND_W'(26'(DAC_FULL) * 26'(num));
        divisor  = {n_eff, 1'b0};
      end
      SHAPE_SAW: begin
        dividend = DIVIDEND_W'(24'(DAC_FULL) * 24'(i_eff));
        divisor  = {1'b0, n_eff};
      end
      default: begin
        dividend = {i_eff, 16'b0};
        divisor  = {1'b0, n_eff};
      end
    endcase
  end

  pwg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (fire && (shape_r != SHAPE_OFF)),
    .dividend (dividend),
    .divisor  (divisor),
    .status   (div_st),
    .quotient (quot)
  );

  assign zprod   = 33'(quot[13:0]) * 33'(TWO_PI_Q16);
  assign cord_in.x = CW'(CORDIC_GAIN);
  assign cord_in.y = '0;
  assign cord_in.z = CW'(z_r);

  pwg_cordic_chain u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (cord_start_r),
    .vec_in  (cord_in),
    .vld_out (cord_vld),
    .vec_out (cord_out)
  );

  always_comb begin
    case (quad_r)
      2'd0: csel = cord_out.x;
      2'd1: csel = -cord_out.y;
      2'd2: csel = -cord_out.x;
      default: csel = cord_out.y;
    endcase
  end

  assign cshift = 18'(19'sd65536 + 19'(c_r));
  assign sprod  = 30'(DAC_FULL) * 30'(cshift);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    phase_nxt  = phase_r;
    sample_nxt = sample_r;
    unique case (state_r)
      ST_IDLE: begin
        if (fire) begin
          cnt_nxt   = '0;
          phase_nxt = ({1'b0, i_eff} + 13'd1 < n_eff) ? 12'(i_eff + 12'd1) : 12'd0;
          if (shape_r == SHAPE_OFF) begin
            sample_nxt = '0;
            state_nxt  = ST_OUT;
          end else begin
            state_nxt = ST_DIV;
          end
        end else if (accept && in_tick && running_r && (reload_r != '0)) begin
          cnt_nxt = cnt_r + 16'd1;
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          if (cur_shape_r == SHAPE_SINE) begin
            state_nxt = ST_ZMUL;
          end else begin
            sample_nxt = quot[11:0];
            state_nxt  = ST_OUT;
          end
        end
      end
      ST_ZMUL: state_nxt = ST_CORD;
      ST_CORD: begin
        if (cord_vld) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        sample_nxt = sprod[28:17];
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      shape_r      <= '0;
      nsamp_r      <= 13'd64;
      reload_r     <= '0;
      running_r    <= 1'b0;
      cnt_r        <= '0;
      phase_r      <= '0;
      cord_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      phase_r      <= phase_nxt;
      cord_start_r <= (state_r == ST_ZMUL);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SHAPE:   shape_r   <= cfg_data[1:0];
          CFG_NSAMP:   nsamp_r   <= cfg_data[12:0];
          CFG_RELOAD:  reload_r  <= cfg_data;
          CFG_RUNNING: running_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    sample_r <= sample_nxt;
    if (fire) begin
      cur_shape_r <= shape_r;
      cur_idx_r   <= i_eff;
    end
    if (state_r == ST_DIV) begin
      z_r    <= zprod[32:16];
      quad_r <= quot[15:14];
    end
    if (state_r == ST_CORD) begin
      if (csel > 20'sd65536) begin
        c_r <= 18'sd65536;
      end else if (csel < -20'sd65536) begin
        c_r <= -18'sd65536;
      end else begin
        c_r <= 18'(csel);
      end
    end
    if (out_load) begin
      out_sample_r <= sample_nxt;
      out_idx_r    <= cur_idx_r;
      out_start_r  <= (cur_idx_r == '0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dac_sample   = out_sample_r;
  assign out_sample_index = out_idx_r;
  assign out_period_start = out_start_r;

  `PWG_ASSERT_IMP(a_div_in_div_state, div_st.busy, state_r == ST_DIV, "divider busy outside DIV")
  `PWG_ASSERT_IMP(a_cord_in_cord_state, cord_vld, state_r == ST_CORD, "cordic result outside CORD")
  `PWG_ASSERT_IMP(a_period_flag, out_valid_r, out_start_r == (out_idx_r == '0), "period_start mismatch")
  `PWG_ASSERT_NXT(a_load_returns_idle, out_load, state_r == ST_IDLE, "no return to idle after load")
endmodule

[sim/periodic_waveform_generator_top_test.sv]
module periodic_waveform_generator_top_test;
  import pwg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int RANDOM_TICKS  = 1850;

  typedef struct {
    logic [11:0] dac;
    logic [11:0] idx;
    logic        start;
  } sample_t;

  typedef enum logic {ROW_CFG, ROW_TICK} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  reg_sel;
    logic [15:0] value;
    logic        tick;
    int          typed_dac;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_tick = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_dac_sample;
  logic [11:0] out_sample_index;
  logic        out_period_start;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // generator model state
  logic [1:0]  m_shape;
  logic [12:0] m_count;
  logic [15:0] m_reload;
  logic        m_running;
  logic [15:0] m_ticks;
  logic [11:0] m_phase;

  sample_t pending_samples[$];
  int      error_count = 0;
  int      cycle_count = 0;
  bit      calm = 0;
  int      hold_request = 0;
  int      hold_left = 0;
  int      stall_burst = 0;

  int arctan_q16[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                         256, 128, 64, 32, 16, 8, 4, 2};

  periodic_waveform_generator_top DUT (.*);

  always #6 clk = ~clk;

  function automatic int sine_level(int i, int n);
    int p, q, r, z, x, y, dx, dy, c;
    p = int'(((longint'(i) << 16) / n) & 'hFFFF);
    q = p >> 14;
    r = p & 'h3FFF;
    z = int'((longint'(r) * TWO_PI_Q16) >>> 16);
    x = CORDIC_GAIN;
    y = 0;
    for (int k = 0; k < 16; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q16[k];
      end else begin
        x += dx; y -= dy; z += arctan_q16[k];
      end
    end
    case (q)
      0: c = x;
      1: c = -y;
      2: c = -x;
      default: c = y;
    endcase
    if (c > 65536) c = 65536;
    if (c < -65536) c = -65536;
    return int'((longint'(DAC_FULL) * (65536 + c)) >>> 17);
  endfunction

  function automatic int triangle_level(int i, int n);
    longint fi, fn, num;
    fi = 4 * longint'(i);
    fn = n;
    if (fi < fn) num = fi + fn;
    else if (fi < 3 * fn) num = 3 * fn - fi;
    else num = fi - 3 * fn;
    return int'((longint'(DAC_FULL) * num) / (2 * fn));
  endfunction

  // Advance the generator by one tick; returns 1 when a sample comes out.
  function automatic bit advance_generator(input logic tick, output sample_t s);
    int n, i, level;
    s = '{default: '0};
    if (!tick || !m_running || m_reload == 0) return 0;
    if (m_ticks < m_reload) begin
      m_ticks = m_ticks + 1;
      return 0;
    end
    m_ticks = 0;
    n = m_count;
    if (n < 2) n = 2;
    if (n > MAX_SAMPLES) n = MAX_SAMPLES;
    i = m_phase;
    if (i >= n) i = 0;
    case (m_shape)
      SHAPE_SINE: level = sine_level(i, n);
      SHAPE_TRI:  level = triangle_level(i, n);
      SHAPE_SAW:  level = int'((longint'(DAC_FULL) * i) / n);
      default:    level = 0;
    endcase
    s.dac = level[11:0];
    s.idx = i[11:0];
    s.start = (i == 0);
    m_phase = (i + 1 < n) ? 12'(i + 1) : 12'd0;
    return 1;
  endfunction

  task automatic write_reg(input logic [1:0] sel, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (sel)
      CFG_SHAPE:  m_shape = value[1:0];
      CFG_NSAMP:  m_count = value[12:0];
      CFG_RELOAD: m_reload = value;
      default:    m_running = value[0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_tick(input logic tick, input int typed_dac);
    sample_t s;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_tick  <= tick;
    do @(posedge clk); while (in_stall);
    if (advance_generator(tick, s)) begin
      if (typed_dac >= 0) s.dac = typed_dac[11:0];
      pending_samples.push_back(s);
    end
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    wait (pending_samples.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    sample_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        $error("sample with nothing expected: dac %0d index %0d",
               out_dac_sample, out_sample_index);
        error_count++;
      end else begin
        e = pending_samples.pop_front();
        if (out_dac_sample !== e.dac) begin
          $error("dac_sample expected %0d actual %0d", e.dac, out_dac_sample);
          error_count++;
        end
        if (out_sample_index !== e.idx) begin
          $error("sample_index expected %0d actual %0d", e.idx, out_sample_index);
          error_count++;
        end
        if (out_period_start !== e.start) begin
          $error("period_start expected %0d actual %0d", e.start, out_period_start);
          error_count++;
        end
      end
    end
  end

  // receiver back-pressure: long hold-off on request, short bursts otherwise
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_burst > 0) begin
      stall_burst--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_burst = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    int   sent;
    int   phase_len;
    logic [15:0] v;

    m_shape = SHAPE_SINE; m_count = 64; m_reload = 0; m_running = 0;
    m_ticks = 0; m_phase = 0;

    rows = '{
      '{ROW_CFG, CFG_SHAPE, SHAPE_SAW, 0, -1}, '{ROW_CFG, CFG_NSAMP, 2, 0, -1},
      '{ROW_CFG, CFG_RELOAD, 1, 0, -1}, '{ROW_CFG, CFG_RUNNING, 1, 0, -1},
      '{ROW_TICK, 0, 0, 1, -1}, '{ROW_TICK, 0, 0, 1, 0}, '{ROW_TICK, 0, 0, 0, -1},
      '{ROW_TICK, 0, 0, 1, -1}, '{ROW_TICK, 0, 0, 1, 2047},
      '{ROW_CFG, CFG_SHAPE, SHAPE_OFF, 0, -1},
      '{ROW_TICK, 0, 0, 1, -1}, '{ROW_TICK, 0, 0, 1, 0},
      '{ROW_CFG, CFG_SHAPE, SHAPE_TRI, 0, -1}, '{ROW_CFG, CFG_NSAMP, 4, 0, -1},
      '{ROW_TICK, 0, 0, 1, -1}, '{ROW_TICK, 0, 0, 1, 4095},
      '{ROW_TICK, 0, 0, 1, -1}, '{ROW_TICK, 0, 0, 1, -1},
      '{ROW_CFG, CFG_SHAPE, SHAPE_SINE, 0, -1}, '{ROW_CFG, CFG_NSAMP, 4096, 0, -1},
      '{ROW_TICK, 0, 0, 1, -1}, '{ROW_TICK, 0, 0, 1, -1},
      '{ROW_CFG, CFG_NSAMP, 0, 0, -1},
      '{ROW_TICK, 0, 0, 1, -1}, '{ROW_TICK, 0, 0, 1, -1},
      '{ROW_CFG, CFG_NSAMP, 16'h1FFF, 0, -1},
      '{ROW_TICK, 0, 0, 1, -1}, '{ROW_TICK, 0, 0, 1, -1},
      '{ROW_CFG, CFG_RELOAD, 0, 0, -1},
      '{ROW_TICK, 0, 0, 1, -1}, '{ROW_TICK, 0, 0, 1, -1},
      '{ROW_CFG, CFG_RUNNING, 0, 0, -1}, '{ROW_CFG, CFG_RELOAD, 16'hFFFF, 0, -1},
      '{ROW_TICK, 0, 0, 1, -1},
      '{ROW_CFG, CFG_RUNNING, 1, 0, -1},
      '{ROW_TICK, 0, 0, 1, -1}, '{ROW_TICK, 0, 0, 1, -1}, '{ROW_TICK, 0, 0, 1, -1},
      '{ROW_CFG, CFG_RELOAD, 2, 0, -1},
      '{ROW_TICK, 0, 0, 1, -1}, '{ROW_TICK, 0, 0, 1, -1}
    };

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[k]) begin
      if (rows[k].kind == ROW_CFG) begin
        drain();
        write_reg(rows[k].reg_sel, rows[k].value);
      end else begin
        send_tick(rows[k].tick, rows[k].typed_dac);
      end
    end

    // hold the receiver off while ticks keep coming, so the block stalls its input
    drain();
    write_reg(CFG_SHAPE, 16'(SHAPE_SAW));
    write_reg(CFG_NSAMP, 16'd8);
    write_reg(CFG_RELOAD, 16'd1);
    write_reg(CFG_RUNNING, 16'd1);
    hold_request = 200;
    repeat (20) send_tick(1'b1, -1);

    sent = 0;
    while (sent < RANDOM_TICKS) begin
      drain();
      if (sent > RANDOM_TICKS - 300) calm = 1;
      // new setting; sample counts stay mostly small so wraps are frequent
      if ($urandom_range(0, 2) != 0) write_reg(CFG_SHAPE, 16'($urandom_range(0, 3)));
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 7))
          0: v = 16'd4096;
          1: v = 16'($urandom_range(0, 1));
          2: v = 16'($urandom());
          default: v = 16'($urandom_range(2, 24));
        endcase
        write_reg(CFG_NSAMP, v);
      end
      if ($urandom_range(0, 9) == 0) begin
        // park the counter high, then lower the reload beneath it
        write_reg(CFG_RELOAD, 16'($urandom_range(200, 65535)));
        write_reg(CFG_RUNNING, 16'd1);
        repeat ($urandom_range(5, 12)) begin
          send_tick(1, -1);
          sent++;
        end
        drain();
      end
      case ($urandom_range(0, 9))
        0: v = 16'd0;
        1: v = 16'($urandom_range(4, 9));
        default: v = 16'($urandom_range(1, 2));
      endcase
      write_reg(CFG_RELOAD, v);
      write_reg(CFG_RUNNING, 16'($urandom_range(0, 9) != 0));
      phase_len = $urandom_range(30, 80);
      if (!calm && $urandom_range(0, 12) == 0) hold_request = $urandom_range(150, 400);
      repeat (phase_len) begin
        send_tick(1'($urandom_range(0, 9) != 0), -1);
        sent++;
      end
    end

    drain();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/pwg_pkg.sv
hdl/pwg_div.sv
hdl/pwg_cordic_cell.sv
hdl/pwg_cordic_chain.sv
hdl/periodic_waveform_generator_top.sv
sim/periodic_waveform_generator_top_test.sv
